// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define SMD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("smd assertion failed");

// condition that must hold in the cycle after a trigger
`define SMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smd assertion failed");

`endif

// File: src/smd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_pkg
// Types and constants shared by the SHA-1 digest front end and core.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_LEN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BK_DATA,
        BK_EXTRA,
        BK_FINAL
    } t_blk;

    typedef logic [0:4][31:0] t_chain;

    localparam t_chain H_INIT = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                 32'h10325476, 32'hC3D2E1F0};

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

// File: src/smd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_front
// Input side: takes byte items, drops bare non-final markers and queues
// the rest for the compression core.
// ----------------------------------------------------------------------------
module smd_front import smd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_last_item,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_item_pop
);

    t_item          r_q [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           push;
    logic           pop;

    assign o_ready      = (r_count != QAW'(0) + (QAW+1)'(QDEPTH));
    assign push         = i_valid && o_ready && (i_has_byte || i_last_item);
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{data: i_data_byte, has: i_has_byte, last: i_last_item};
        end
    end

endmodule

// File: src/smd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_core
// Block assembly, padding, 80-round compression and digest output register.
// ----------------------------------------------------------------------------
module smd_core import smd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_item_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state             r_state;
    t_state             n_state;
    t_blk               r_kind;
    logic               r_fin;
    logic [5:0]         r_fill;
    logic [63:0]        r_bits;
    logic [6:0]         r_round;
    logic [2:0]         r_ocnt;
    t_chain             r_chain;
    logic [31:0]        r_win [16];
    logic [31:0]        r_wk  [5];
    logic               r_ovalid;
    logic [31:0]        r_oword;
    logic [2:0]         r_oidx;
    logic               r_olast;

    logic               take_byte;
    logic               block_full;
    logic               out_load;
    logic [31:0]        pad_win [16];
    logic [31:0]        len_win [16];
    logic [31:0]        f_val;
    logic [31:0]        k_val;
    logic [31:0]        t_val;
    logic [31:0]        w_next;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (i_item_valid) begin
                    if (i_item.has && r_fill == FILL_LAST) begin
                        n_state = ST_ROUND;
                    end else if (i_item.last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_LEN:   n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                case (r_kind)
                    BK_DATA:  n_state = r_fin ? ST_PAD : ST_FILL;
                    BK_EXTRA: n_state = ST_LEN;
                    BK_FINAL: n_state = ST_OUT;
                    default:  n_state = ST_FILL;
                endcase
            end
            ST_OUT: begin
                if (out_load && r_ocnt == WORD_LAST) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // control outputs
    always_comb begin
        o_item_pop = (r_state == ST_FILL) && i_item_valid;
        take_byte  = o_item_pop && i_item.has;
        block_full = take_byte && (r_fill == FILL_LAST);
        out_load   = (r_state == ST_OUT) && (!r_ovalid || i_ready);
    end

    // padding of the current block, length in place when it fits
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            for (int b = 0; b < 4; b++) begin
                if (6'(4 * j + b) < r_fill) begin
                    pad_win[j][31 - 8 * b -: 8] = r_win[j][31 - 8 * b -: 8];
                end else if (6'(4 * j + b) == r_fill) begin
                    pad_win[j][31 - 8 * b -: 8] = PAD_BYTE;
                end else begin
                    pad_win[j][31 - 8 * b -: 8] = 8'h00;
                end
            end
            len_win[j] = '0;
        end
        if (r_fill < LEN_POS) begin
            pad_win[14] = r_bits[63:32];
            pad_win[15] = r_bits[31:0];
        end
        len_win[14] = r_bits[63:32];
        len_win[15] = r_bits[31:0];
    end

    // one compression round
    always_comb begin
        if (r_round < ROUND_20) begin
            f_val = (r_wk[1] & r_wk[2]) | (~r_wk[1] & r_wk[3]);
            k_val = K_R0;
        end else if (r_round < ROUND_40) begin
            f_val = r_wk[1] ^ r_wk[2] ^ r_wk[3];
            k_val = K_R1;
        end else if (r_round < ROUND_60) begin
            f_val = (r_wk[1] & r_wk[2]) | (r_wk[1] & r_wk[3]) | (r_wk[2] & r_wk[3]);
            k_val = K_R2;
        end else begin
            f_val = r_wk[1] ^ r_wk[2] ^ r_wk[3];
            k_val = K_R3;
        end
        t_val  = {r_wk[0][26:0], r_wk[0][31:27]} + f_val + r_wk[4] + k_val + r_win[0];
        w_next = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_next = {w_next[30:0], w_next[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FILL;
            r_kind   <= BK_DATA;
            r_fin    <= 1'b0;
            r_fill   <= '0;
            r_bits   <= '0;
            r_round  <= '0;
            r_ocnt   <= '0;
            r_chain  <= H_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_byte) begin
                r_fill <= r_fill + 6'd1;
                r_bits <= r_bits + 64'd8;
            end
            if (block_full) begin
                r_kind <= BK_DATA;
                r_fin  <= i_item.last;
            end
            if (r_state == ST_PAD) begin
                r_kind <= (r_fill < LEN_POS) ? BK_FINAL : BK_EXTRA;
                r_fin  <= 1'b0;
            end
            if (r_state == ST_LEN) begin
                r_kind <= BK_FINAL;
            end
            if (r_state == ST_ROUND) begin
                r_round <= (r_round == ROUND_LAST) ? '0 : r_round + 7'd1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < 5; i++) begin
                    r_chain[i] <= r_chain[i] + r_wk[i];
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                if (r_ocnt == WORD_LAST) begin
                    r_ocnt  <= '0;
                    r_chain <= H_INIT;
                    r_fill  <= '0;
                    r_bits  <= '0;
                end else begin
                    r_ocnt <= r_ocnt + 3'd1;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_item.data;
        end
        if (block_full || r_state == ST_PAD || r_state == ST_LEN) begin
            for (int i = 0; i < 5; i++) begin
                r_wk[i] <= r_chain[i];
            end
        end
        if (r_state == ST_PAD) begin
            r_win <= pad_win;
        end
        if (r_state == ST_LEN) begin
            r_win <= len_win;
        end
        if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_next;
            r_wk[4]   <= r_wk[3];
            r_wk[3]   <= r_wk[2];
            r_wk[2]   <= {r_wk[1][1:0], r_wk[1][31:2]};
            r_wk[1]   <= r_wk[0];
            r_wk[0]   <= t_val;
        end
        if (out_load) begin
            r_oword <= r_chain[r_ocnt];
            r_oidx  <= r_ocnt;
            r_olast <= (r_ocnt == WORD_LAST);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

endmodule

// File: src/sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, digest returned as five 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: one message byte per transfer (i_data_byte, i_has_byte),
// i_last_item closes the message; i_has_byte low with i_last_item high ends
// a message without a byte, so an empty message hashes correctly.
// Output channel: five transfers per message, o_word_index 0..4, first
// digest word first, o_last_word on the fifth.
// Bytes enter a four-entry queue; the core packs one byte per cycle while
// filling a block and runs one SHA-1 round per cycle, adds the chaining
// values after the rounds, and takes no bytes while it compresses.
// After the last byte the core pads and compresses the block, plus a
// further length block when 56 or more bytes sit in the final block; the
// words leave through an output register, one per cycle when not stalled.
// A stalled receiver holds the current word; bytes keep queuing until the
// queue is full. Reset empties the queue, clears counters and restores the
// initial chaining values; after each digest counters and chaining return too.
// ----------------------------------------------------------------------------
module sha1_message_digest import smd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic  item_valid;
    t_item item;
    logic  item_pop;

    smd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_last_item  (i_last_item),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    smd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// File: src/smd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks on the digest output sequence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_digest_word,
    input  logic [2:0]  o_word_index,
    input  logic        o_last_word
);

    `SMD_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `SMD_ASSERT_NEXT(a_hold_word, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_digest_word))
    `SMD_ASSERT(a_index_range, i_clk, i_rst_n, !o_valid || o_word_index <= 3'd4)
    `SMD_ASSERT(a_last_flag, i_clk, i_rst_n, !o_valid || (o_last_word == (o_word_index == 3'd4)))
    `SMD_ASSERT(a_index_step, i_clk, i_rst_n, (o_valid && i_ready && !o_last_word) ##1 o_valid |-> (o_word_index == $past(o_word_index) + 3'd1))

endmodule

bind sha1_message_digest smd_checker u_smd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
